[rtl/xtl_pkg.sv]
// shared types, constants and helpers for the xml token lexer
// no dependencies; imported by every module of the block
`default_nettype none

package xtl_pkg;

  localparam int NAME_DEPTH_DEF  = 32;
  localparam int SPACE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 36;
  localparam int CNT_W           = 6;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [3:0] K_UNDEF      = 4'd0;
  localparam logic [3:0] K_OPEN       = 4'd1;
  localparam logic [3:0] K_CLOSE      = 4'd2;
  localparam logic [3:0] K_PI_OPEN    = 4'd3;
  localparam logic [3:0] K_PI_CLOSE   = 4'd4;
  localparam logic [3:0] K_ATTR_NAME  = 4'd5;
  localparam logic [3:0] K_ATTR_VALUE = 4'd6;
  localparam logic [3:0] K_TEXT       = 4'd7;
  localparam logic [3:0] K_END        = 4'd8;

  typedef enum logic [3:0] {
    M_IDLE, M_TAG_START, M_CLOSE_START, M_PI_START, M_NAME_OPEN, M_NAME_CLOSE,
    M_NAME_PI, M_ATTR_NAME, M_ATTR_VALUE, M_TEXT, M_SWALLOW
  } mode_t;

  typedef enum logic [1:0] {B_NONE, B_ONE, B_REPLAY, B_SPACE} body_t;

  typedef enum logic [1:0] {SRC_PRE, SRC_ONE, SRC_MEM, SRC_CHAR} src_t;

  typedef enum logic [2:0] {ST_IDLE, ST_PRE, ST_FETCH, ST_MEM, ST_ONE, ST_CHAR} ctl_state_t;

  typedef struct packed {
    logic load;
    logic emit;
    src_t src;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic  out_free;
    logic  nxt_pre;
    body_t nxt_body;
    body_t body;
    logic  last;
    logic  more;
  } sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

[rtl/xtl_datapath.sv]
// lexer datapath: byte decode, lexer state, name and space stores, output register
// depends on xtl_pkg
`default_nettype none

module xtl_datapath import xtl_pkg::*; #(
  parameter int NAME_DEPTH  = NAME_DEPTH_DEF,
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic       out_tready,
  output logic            out_valid,
  output logic [3:0]      out_kind,
  output logic            out_has,
  output logic [7:0]      out_char,
  output logic            out_st,
  output logic            out_en,
  output logic            out_last
);

  localparam int NLEN_W = $clog2(NAME_DEPTH + 1);
  localparam int SLEN_W = $clog2(SPACE_DEPTH + 1);
  localparam int LEN_W  = (NLEN_W > SLEN_W) ? NLEN_W : SLEN_W;
  localparam int NAW    = $clog2(NAME_DEPTH);
  localparam int SAW    = $clog2(SPACE_DEPTH);

  mode_t             mode_r, mode_nxt;
  logic              inside_r, inside_nxt;
  logic              between_r, between_nxt;
  logic [NLEN_W-1:0] nlen_r, nlen_nxt;
  logic [SLEN_W-1:0] scnt_r, scnt_nxt;

  logic [7:0] name_mem  [NAME_DEPTH];
  logic [7:0] space_mem [SPACE_DEPTH];
  logic [7:0] name_rd_r, space_rd_r;
  logic           name_we, space_we;
  logic [NAW-1:0] name_wa;

  // registered plan of the results of the current word
  logic             pre_nxt;
  logic [3:0]       prek_r, prek_nxt;
  body_t            body_r, body_nxt;
  logic [3:0]       onek_r, onek_nxt;
  logic             oneh_r, oneh_nxt;
  logic [7:0]       onec_r, onec_nxt;
  logic             ones_r, ones_nxt;
  logic             onee_r, onee_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;

  logic       out_valid_r;
  logic [3:0] kind_r;
  logic       has_r, st_r, en_r, last_r;
  logic [7:0] char_r;

  logic       ws;
  logic [3:0] tk;
  logic       bn, nm;
  logic [3:0] bn_kind, nm_kind;
  mode_t      bn_mode;

  logic [3:0] e_kind;
  logic       e_has, e_st, e_en, e_last, fin;
  logic [7:0] e_char;

  assign ws = is_ws(in_byte);
  assign tk = between_r ? K_TEXT : K_UNDEF;

  always_comb begin
    mode_nxt    = mode_r;
    inside_nxt  = inside_r;
    between_nxt = between_r;
    nlen_nxt    = nlen_r;
    scnt_nxt    = scnt_r;
    name_we     = 1'b0;
    name_wa     = nlen_r[NAW-1:0];
    space_we    = 1'b0;
    pre_nxt     = 1'b0;
    prek_nxt    = K_UNDEF;
    body_nxt    = B_NONE;
    onek_nxt    = K_UNDEF;
    oneh_nxt    = 1'b0;
    onec_nxt    = 8'h00;
    ones_nxt    = 1'b0;
    onee_nxt    = 1'b0;
    plen_nxt    = '0;
    bn          = 1'b0;
    bn_kind     = K_OPEN;
    bn_mode     = M_NAME_OPEN;
    nm          = 1'b0;
    nm_kind     = K_OPEN;
    if (in_end) begin
      case (mode_r)
        M_NAME_OPEN: begin
          pre_nxt = 1'b1; prek_nxt = K_OPEN; between_nxt = 1'b1;
        end
        M_NAME_CLOSE: begin
          pre_nxt = 1'b1; prek_nxt = K_CLOSE; between_nxt = 1'b0;
        end
        M_NAME_PI: begin
          pre_nxt = 1'b1; prek_nxt = K_PI_OPEN;
        end
        M_ATTR_NAME: begin
          pre_nxt = 1'b1; prek_nxt = K_ATTR_NAME;
        end
        M_ATTR_VALUE: begin
          pre_nxt = 1'b1; prek_nxt = K_ATTR_VALUE;
        end
        M_TEXT: begin
          pre_nxt = 1'b1; prek_nxt = tk; scnt_nxt = '0;
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;
      body_nxt = B_ONE;
      onek_nxt = K_END;
      ones_nxt = 1'b1;
      onee_nxt = 1'b1;
    end else begin
      case (mode_r)
        M_TAG_START: begin
          if (!ws) begin
            if (in_byte == CH_GT) begin
              body_nxt = B_ONE; onek_nxt = K_OPEN; ones_nxt = 1'b1; onee_nxt = 1'b1;
              between_nxt = 1'b1;
              mode_nxt = M_IDLE;
            end else if (in_byte == CH_SLASH) begin
              mode_nxt = M_CLOSE_START;
            end else if (in_byte == CH_QM) begin
              mode_nxt = M_PI_START;
            end else begin
              bn = 1'b1; bn_kind = K_OPEN; bn_mode = M_NAME_OPEN;
            end
          end
        end
        M_CLOSE_START: begin
          if (!ws) begin
            if (in_byte == CH_GT) begin
              body_nxt = B_ONE; onek_nxt = K_CLOSE; ones_nxt = 1'b1; onee_nxt = 1'b1;
              between_nxt = 1'b0;
              mode_nxt = M_IDLE;
            end else begin
              bn = 1'b1; bn_kind = K_CLOSE; bn_mode = M_NAME_CLOSE;
            end
          end
        end
        M_PI_START: begin
          if (!ws) begin
            bn = 1'b1; bn_kind = K_PI_OPEN; bn_mode = M_NAME_PI;
          end
        end
        M_NAME_OPEN: begin
          nm = 1'b1; nm_kind = K_OPEN;
        end
        M_NAME_CLOSE: begin
          nm = 1'b1; nm_kind = K_CLOSE;
        end
        M_NAME_PI: begin
          nm = 1'b1; nm_kind = K_PI_OPEN;
        end
        M_ATTR_NAME: begin
          if (!ws) begin
            body_nxt = B_ONE; onek_nxt = K_ATTR_NAME;
            if (in_byte == CH_EQ) begin
              onee_nxt = 1'b1; mode_nxt = M_IDLE;
            end else begin
              oneh_nxt = 1'b1; onec_nxt = in_byte;
            end
          end
        end
        M_ATTR_VALUE: begin
          body_nxt = B_ONE; onek_nxt = K_ATTR_VALUE;
          if (in_byte == CH_QUOTE) begin
            onee_nxt = 1'b1; mode_nxt = M_IDLE;
          end else begin
            oneh_nxt = 1'b1; onec_nxt = in_byte;
          end
        end
        M_TEXT: begin
          if (in_byte == CH_LT) begin
            pre_nxt = 1'b1; prek_nxt = tk; scnt_nxt = '0;
            nlen_nxt = '0; mode_nxt = M_TAG_START;
          end else if (ws) begin
            if (scnt_r < SLEN_W'(SPACE_DEPTH)) begin
              space_we = 1'b1;
              scnt_nxt = scnt_r + 1'b1;
            end
          end else begin
            // held whitespace goes out ahead of the character
            onek_nxt = tk; oneh_nxt = 1'b1; onec_nxt = in_byte;
            body_nxt = (scnt_r != '0) ? B_SPACE : B_ONE;
            plen_nxt = LEN_W'(scnt_r);
            scnt_nxt = '0;
          end
        end
        M_SWALLOW: begin
          if (!ws) mode_nxt = M_IDLE;
        end
        default: begin
          mode_nxt = M_IDLE;
          if (!ws) begin
            if (in_byte == CH_LT) begin
              nlen_nxt = '0; mode_nxt = M_TAG_START;
            end else if (in_byte == CH_SLASH) begin
              between_nxt = 1'b0;
              onek_nxt = K_CLOSE;
              if (nlen_r == '0) begin
                body_nxt = B_ONE; ones_nxt = 1'b1; onee_nxt = 1'b1;
              end else begin
                body_nxt = B_REPLAY; plen_nxt = LEN_W'(nlen_r);
              end
            end else if (in_byte == CH_GT) begin
              inside_nxt = 1'b0;
            end else if (in_byte == CH_QM) begin
              body_nxt = B_ONE; onek_nxt = K_PI_CLOSE; ones_nxt = 1'b1; onee_nxt = 1'b1;
              mode_nxt = M_SWALLOW;
            end else if (in_byte == CH_QUOTE) begin
              body_nxt = B_ONE; onek_nxt = K_ATTR_VALUE; ones_nxt = 1'b1;
              mode_nxt = M_ATTR_VALUE;
            end else begin
              body_nxt = B_ONE; oneh_nxt = 1'b1; onec_nxt = in_byte; ones_nxt = 1'b1;
              if (inside_r) begin
                onek_nxt = K_ATTR_NAME; mode_nxt = M_ATTR_NAME;
              end else begin
                onek_nxt = tk; scnt_nxt = '0; mode_nxt = M_TEXT;
              end
            end
          end
        end
      endcase

      if (bn) begin
        inside_nxt = 1'b1;
        body_nxt = B_ONE; onek_nxt = bn_kind; oneh_nxt = 1'b1; onec_nxt = in_byte;
        ones_nxt = 1'b1;
        name_we = 1'b1; name_wa = '0; nlen_nxt = NLEN_W'(1);
        mode_nxt = bn_mode;
      end

      if (nm) begin
        if (in_byte == CH_SLASH) begin
          // name ends, slash then replays the stored name as a close tag
          pre_nxt = 1'b1; prek_nxt = nm_kind;
          between_nxt = 1'b0; mode_nxt = M_IDLE;
          onek_nxt = K_CLOSE;
          if (nlen_r == '0) begin
            body_nxt = B_ONE; ones_nxt = 1'b1; onee_nxt = 1'b1;
          end else begin
            body_nxt = B_REPLAY; plen_nxt = LEN_W'(nlen_r);
          end
        end else if (ws || (in_byte == CH_GT)) begin
          if (in_byte == CH_GT) inside_nxt = 1'b0;
          body_nxt = B_ONE; onek_nxt = nm_kind; onee_nxt = 1'b1;
          if (nm_kind == K_OPEN) between_nxt = 1'b1;
          else if (nm_kind == K_CLOSE) between_nxt = 1'b0;
          mode_nxt = M_IDLE;
        end else begin
          body_nxt = B_ONE; onek_nxt = nm_kind; oneh_nxt = 1'b1; onec_nxt = in_byte;
          if (nlen_r < NLEN_W'(NAME_DEPTH)) begin
            name_we = 1'b1; nlen_nxt = nlen_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && name_we) name_mem[name_wa] <= in_byte;
    if (cmd.load && space_we) space_mem[scnt_r[SAW-1:0]] <= in_byte;
    name_rd_r  <= name_mem[idx_r[NAW-1:0]];
    space_rd_r <= space_mem[idx_r[SAW-1:0]];
  end

  // result selection for the current emit source
  assign fin = (idx_r + 1'b1) == plen_r;

  always_comb begin
    e_kind = onek_r;
    e_has  = 1'b1;
    e_char = onec_r;
    e_st   = 1'b0;
    e_en   = 1'b0;
    e_last = 1'b1;
    case (cmd.src)
      SRC_PRE: begin
        e_kind = prek_r; e_has = 1'b0; e_char = 8'h00; e_en = 1'b1;
        e_last = (body_r == B_NONE);
      end
      SRC_ONE: begin
        e_has = oneh_r; e_st = ones_r; e_en = onee_r;
      end
      SRC_MEM: begin
        if (body_r == B_REPLAY) begin
          e_kind = K_CLOSE; e_char = name_rd_r;
          e_st = (idx_r == '0); e_en = fin; e_last = fin;
        end else begin
          e_char = space_rd_r; e_last = 1'b0;
        end
      end
      default: ;
    endcase
    if (cnt_r == CNT_W'(MAX_RESULTS - 1)) e_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      inside_r    <= 1'b0;
      between_r   <= 1'b0;
      nlen_r      <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cmd.load) begin
        mode_r    <= mode_nxt;
        inside_r  <= inside_nxt;
        between_r <= between_nxt;
        nlen_r    <= nlen_nxt;
        scnt_r    <= scnt_nxt;
        idx_r     <= '0;
        cnt_r     <= '0;
      end else begin
        if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
        if (cmd.emit) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prek_r <= prek_nxt;
      body_r <= body_nxt;
      onek_r <= onek_nxt;
      oneh_r <= oneh_nxt;
      onec_r <= onec_nxt;
      ones_r <= ones_nxt;
      onee_r <= onee_nxt;
      plen_r <= plen_nxt;
    end
    if (cmd.emit) begin
      kind_r <= e_kind;
      has_r  <= e_has;
      char_r <= e_char;
      st_r   <= e_st;
      en_r   <= e_en;
      last_r <= e_last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.nxt_pre  = pre_nxt;
  assign sts.nxt_body = body_nxt;
  assign sts.body     = body_r;
  assign sts.last     = e_last;
  assign sts.more     = !fin;

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_has   = has_r;
  assign out_char  = char_r;
  assign out_st    = st_r;
  assign out_en    = en_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

[rtl/xtl_ctrl.sv]
// lexer controller: sequences the results of one word into the output register
// depends on xtl_pkg
`default_nettype none

module xtl_ctrl import xtl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          if (sts.nxt_pre) state_nxt = ST_PRE;
          else begin
            case (sts.nxt_body)
              B_ONE:    state_nxt = ST_ONE;
              B_REPLAY: state_nxt = ST_FETCH;
              B_SPACE:  state_nxt = ST_FETCH;
              default:  state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_PRE: begin
        if (cmd.emit) begin
          if (sts.last) state_nxt = ST_IDLE;
          else if (sts.body == B_ONE) state_nxt = ST_ONE;
          else state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_MEM;
      ST_MEM: begin
        if (cmd.emit) begin
          if (sts.last) state_nxt = ST_IDLE;
          else if (sts.more) state_nxt = ST_FETCH;
          else state_nxt = ST_CHAR;
        end
      end
      ST_ONE, ST_CHAR: begin
        if (cmd.emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    cmd.load    = in_tvalid && (state_r == ST_IDLE);
    cmd.emit    = 1'b0;
    cmd.src     = SRC_ONE;
    cmd.idx_inc = 1'b0;
    case (state_r)
      ST_PRE: begin
        cmd.src = SRC_PRE; cmd.emit = sts.out_free;
      end
      ST_MEM: begin
        cmd.src = SRC_MEM; cmd.emit = sts.out_free; cmd.idx_inc = sts.out_free;
      end
      ST_ONE: begin
        cmd.src = SRC_ONE; cmd.emit = sts.out_free;
      end
      ST_CHAR: begin
        cmd.src = SRC_CHAR; cmd.emit = sts.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

`default_nettype wire

[rtl/xml_token_lexer.sv]
// sequencing: a word is taken only while the controller is idle; its first result
//   is registered from state PRE or ONE, or via FETCH and MEM from the name or whitespace store
// flow: a word with no result leaves the controller idle; other words hold off input
//   until their last result is out; each replayed name char or flushed space passes FETCH then MEM
// reset: synchronous active-low rst_n returns the lexer to idle between tokens and
//   clears the name length and held-space count; store contents are not cleared
`default_nettype none

module xml_token_lexer import xtl_pkg::*; #(
  parameter int NAME_DEPTH  = NAME_DEPTH_DEF,
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // stream_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] char_value, [8] starts_token, [9] ends_token
  output logic [4:0]       out_tuser,  // [3:0] token_kind, [4] has_char
  output logic             out_tlast   // last_of_run
);

  cmd_t cmd;
  sts_t sts;

  logic [3:0] kind;
  logic       has, st, en;
  logic [7:0] chr;

  // controller walks the planned results of each word
  xtl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath decodes the word, holds lexer state, stores and output register
  xtl_datapath #(
    .NAME_DEPTH  (NAME_DEPTH),
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_end     (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (kind),
    .out_has    (has),
    .out_char   (chr),
    .out_st     (st),
    .out_en     (en),
    .out_last   (out_tlast)
  );

  // pack result fields, pad bits held at zero
  assign out_tdata = {6'b0, en, st, chr};
  assign out_tuser = {has, kind};

endmodule

`default_nettype wire

[rtl/xtl_checker.sv]
// port-level checks on the xml token lexer output stream, bound to the top level
// depends on xtl_pkg
`default_nettype none

module xtl_checker import xtl_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [4:0]  out_tuser,
  input wire logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_charless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[4] |-> out_tdata[7:0] == 8'h00)
    else $error("charless result carries a character");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[3:0] <= K_END)
    else $error("token kind out of range");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:0] == K_END |-> out_tlast && out_tdata[8] && out_tdata[9])
    else $error("end token not a single closing result");

endmodule

bind xml_token_lexer xtl_checker u_xtl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[dv/xml_token_lexer_tb.sv]
// self-checking testbench for the xml token lexer: stream bytes in, token characters out
// depends on xtl_pkg and xml_token_lexer; predicts every result word and compares in order
`timescale 1ns / 1ps

module xml_token_lexer_tb import xtl_pkg::*;;

  localparam int NAME_DEPTH  = NAME_DEPTH_DEF;
  localparam int SPACE_DEPTH = SPACE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0] kind;
    logic       has_char;
    logic [7:0] char_value;
    logic       starts;
    logic       ends;
    logic       last;
  } token_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [4:0] out_tuser;
  logic out_tlast;

  xml_token_lexer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state, mirrors the lexer's own registers
  mode_t      lx_mode;
  logic       lx_in_tag;
  logic       lx_between;
  logic [7:0] lx_name [NAME_DEPTH];
  int         lx_name_len;
  logic [7:0] lx_space [SPACE_DEPTH];
  int         lx_space_cnt;
  int         step_words;

  token_word_t expected_tokens[$];
  in_word_t    pending_bytes[$];
  int          n_errors = 0;
  int          n_cycles = 0;
  bit          hold_sender = 1'b0;
  bit          calm = 1'b0;

  function automatic bit ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [3:0] text_kind();
    return lx_between ? K_TEXT : K_UNDEF;
  endfunction

  // appends one predicted word, capped per input word like the hardware
  function automatic void push_tok(logic [3:0] k, logic h, logic [7:0] c, logic s, logic e);
    token_word_t t;
    if (step_words >= MAX_RESULTS) return;
    t.kind = k; t.has_char = h; t.char_value = h ? c : 8'h00;
    t.starts = s; t.ends = e; t.last = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
    step_words++;
  endfunction

  function automatic void keep_name_char(logic [7:0] c);
    if (lx_name_len < NAME_DEPTH) begin
      lx_name[lx_name_len] = c;
      lx_name_len++;
    end
  endfunction

  function automatic void end_name(logic [3:0] k);
    push_tok(k, 1'b0, 8'h00, 1'b0, 1'b1);
    if (k == K_OPEN) lx_between = 1'b1;
    else if (k == K_CLOSE) lx_between = 1'b0;
    lx_mode = M_IDLE;
  endfunction

  function automatic void flush_token();
    case (lx_mode)
      M_NAME_OPEN:  end_name(K_OPEN);
      M_NAME_CLOSE: end_name(K_CLOSE);
      M_NAME_PI:    end_name(K_PI_OPEN);
      M_ATTR_NAME:  push_tok(K_ATTR_NAME, 1'b0, 8'h00, 1'b0, 1'b1);
      M_ATTR_VALUE: push_tok(K_ATTR_VALUE, 1'b0, 8'h00, 1'b0, 1'b1);
      M_TEXT: begin
        lx_space_cnt = 0;
        push_tok(text_kind(), 1'b0, 8'h00, 1'b0, 1'b1);
      end
      default: ;
    endcase
    lx_mode = M_IDLE;
  endfunction

  // self-closing slash: the stored name comes back as a close tag
  function automatic void replay_close();
    if (lx_name_len == 0) push_tok(K_CLOSE, 1'b0, 8'h00, 1'b1, 1'b1);
    else for (int i = 0; i < lx_name_len; i++)
      push_tok(K_CLOSE, 1'b1, lx_name[i], i == 0, i + 1 == lx_name_len);
    lx_between = 1'b0;
  endfunction

  function automatic void start_name(logic [3:0] k, logic [7:0] c, mode_t nxt);
    lx_in_tag = 1'b1;
    push_tok(k, 1'b1, c, 1'b1, 1'b0);
    lx_name_len = 0;
    keep_name_char(c);
    lx_mode = nxt;
  endfunction

  function automatic void idle_char(logic [7:0] c);
    if (ws(c)) return;
    case (c)
      CH_LT: begin
        lx_name_len = 0;
        lx_mode = M_TAG_START;
      end
      CH_SLASH: replay_close();
      CH_GT:    lx_in_tag = 1'b0;
      CH_QM: begin
        push_tok(K_PI_CLOSE, 1'b0, 8'h00, 1'b1, 1'b1);
        lx_mode = M_SWALLOW;
      end
      CH_QUOTE: begin
        push_tok(K_ATTR_VALUE, 1'b0, 8'h00, 1'b1, 1'b0);
        lx_mode = M_ATTR_VALUE;
      end
      default:
        if (lx_in_tag) begin
          push_tok(K_ATTR_NAME, 1'b1, c, 1'b1, 1'b0);
          lx_mode = M_ATTR_NAME;
        end else begin
          push_tok(text_kind(), 1'b1, c, 1'b1, 1'b0);
          lx_space_cnt = 0;
          lx_mode = M_TEXT;
        end
    endcase
  endfunction

  function automatic void name_char(logic [3:0] k, logic [7:0] c);
    if (c == CH_SLASH) begin
      end_name(k);
      idle_char(c);
    end else if (ws(c)) end_name(k);
    else if (c == CH_GT) begin
      lx_in_tag = 1'b0;
      end_name(k);
    end else begin
      push_tok(k, 1'b1, c, 1'b0, 1'b0);
      keep_name_char(c);
    end
  endfunction

  // held whitespace only comes out ahead of the next visible text character
  function automatic void text_char(logic [7:0] c);
    logic [3:0] k;
    k = text_kind();
    if (c == CH_LT) begin
      flush_token();
      idle_char(c);
    end else if (ws(c)) begin
      if (lx_space_cnt < SPACE_DEPTH) begin
        lx_space[lx_space_cnt] = c;
        lx_space_cnt++;
      end
    end else begin
      for (int i = 0; i < lx_space_cnt; i++) push_tok(k, 1'b1, lx_space[i], 1'b0, 1'b0);
      lx_space_cnt = 0;
      push_tok(k, 1'b1, c, 1'b0, 1'b0);
    end
  endfunction

  function automatic void predict_tokens(in_word_t w);
    logic [7:0] c;
    int first;
    token_word_t t;
    c = w.data_byte;
    step_words = 0;
    first = expected_tokens.size();
    if (w.stream_end) begin
      flush_token();
      push_tok(K_END, 1'b0, 8'h00, 1'b1, 1'b1);
    end else begin
      case (lx_mode)
        M_TAG_START:
          if (!ws(c)) begin
            if (c == CH_GT) begin
              push_tok(K_OPEN, 1'b0, 8'h00, 1'b1, 1'b1);
              lx_between = 1'b1;
              lx_mode = M_IDLE;
            end else if (c == CH_SLASH) lx_mode = M_CLOSE_START;
            else if (c == CH_QM) lx_mode = M_PI_START;
            else start_name(K_OPEN, c, M_NAME_OPEN);
          end
        M_CLOSE_START:
          if (!ws(c)) begin
            if (c == CH_GT) begin
              push_tok(K_CLOSE, 1'b0, 8'h00, 1'b1, 1'b1);
              lx_between = 1'b0;
              lx_mode = M_IDLE;
            end else start_name(K_CLOSE, c, M_NAME_CLOSE);
          end
        M_PI_START:   if (!ws(c)) start_name(K_PI_OPEN, c, M_NAME_PI);
        M_NAME_OPEN:  name_char(K_OPEN, c);
        M_NAME_CLOSE: name_char(K_CLOSE, c);
        M_NAME_PI:    name_char(K_PI_OPEN, c);
        M_ATTR_NAME:
          if (!ws(c)) begin
            if (c == CH_EQ) begin
              push_tok(K_ATTR_NAME, 1'b0, 8'h00, 1'b0, 1'b1);
              lx_mode = M_IDLE;
            end else push_tok(K_ATTR_NAME, 1'b1, c, 1'b0, 1'b0);
          end
        M_ATTR_VALUE:
          if (c == CH_QUOTE) begin
            push_tok(K_ATTR_VALUE, 1'b0, 8'h00, 1'b0, 1'b1);
            lx_mode = M_IDLE;
          end else push_tok(K_ATTR_VALUE, 1'b1, c, 1'b0, 1'b0);
        M_TEXT: text_char(c);
        M_SWALLOW: if (!ws(c)) lx_mode = M_IDLE;
        default: begin
          lx_mode = M_IDLE;
          idle_char(c);
        end
      endcase
    end
    if (expected_tokens.size() > first) begin
      t = expected_tokens[$];
      t.last = 1'b1;
      expected_tokens[$] = t;
    end
  endfunction

  // stimulus helpers
  function automatic void add_byte(logic [7:0] b);
    in_word_t w;
    w.data_byte = b; w.stream_end = 1'b0;
    pending_bytes.insert(pending_bytes.size(), w);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // stream end carries a random byte to show it is ignored
  function automatic void add_end();
    in_word_t w;
    w.data_byte = 8'($urandom); w.stream_end = 1'b1;
    pending_bytes.insert(pending_bytes.size(), w);
  endfunction

  function automatic logic [7:0] name_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic void add_name(int n);
    for (int i = 0; i < n; i++) add_byte(name_letter());
  endfunction

  function automatic void add_ws();
    logic [7:0] w;
    w = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(0, 4));
    add_byte(w);
  endfunction

  // one well-formed-ish element with random content
  function automatic void add_element();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
    add_byte(CH_LT);
    add_name(n);
    repeat ($urandom_range(0, 2)) begin
      add_ws();
      add_name($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) add_ws();
      add_byte(CH_EQ);
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 5))
        add_byte($urandom_range(0, 255) == 34 ? 8'h41 : 8'($urandom));
      add_byte(CH_QUOTE);
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte(CH_SLASH);
      add_byte(CH_GT);
    end else begin
      add_byte(CH_GT);
      repeat ($urandom_range(0, 4)) add_byte(name_letter());
      repeat ($urandom_range(0, 20)) add_ws();
      add_name($urandom_range(0, 3));
      add_str("</");
      add_name(n);
      add_byte(CH_GT);
    end
  endfunction

  // stimulus: directed corners, then mostly structured documents plus noise
  initial begin
    lx_mode = M_IDLE; lx_in_tag = 1'b0; lx_between = 1'b0;
    lx_name_len = 0; lx_space_cnt = 0;
    add_str("<a>x \t\n\v\f\ry</a>");
    add_str("<>t</><b/>");
    add_str("<?p q?> <c k = \"v\">");
    add_str("/");
    add_byte(8'hFF); add_byte(8'h00);
    add_end();
    add_str("<");
    add_end();
    add_str("<?");
    add_end();
    add_str("x ");
    add_end();
    while (pending_bytes.size() < 460) begin
      if ($urandom_range(0, 9) < 8) add_element();
      else repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      if ($urandom_range(0, 15) == 0) add_end();
    end
    add_end();
  end

  // sender: idles at random except in the calm stretch; holds off once for drain
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    calm <= (n_cycles > 300 && n_cycles < 800);
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid && in_tready) predict_tokens('{in_tdata, in_tlast});
        if (pending_bytes.size() == 280 && !hold_sender && expected_tokens.size() != 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
          if (pending_bytes.size() == 280) hold_sender <= 1'b1;
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes[0].data_byte;
          in_tlast  <= pending_bytes[0].stream_end;
          void'(pending_bytes.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || $urandom_range(0, 99) >= 13;
    end
  end

  // monitor: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    token_word_t got, exp_t;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[3:0]; got.has_char = out_tuser[4];
      got.char_value = out_tdata[7:0]; got.starts = out_tdata[8];
      got.ends = out_tdata[9]; got.last = out_tlast;
      if (expected_tokens.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < 10) $display("unexpected result word %h", got);
      end else begin
        exp_t = expected_tokens.pop_front();
        if (got !== exp_t) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("mismatch: kind %0d/%0d has %b/%b char %h/%h st %b/%b en %b/%b last %b/%b",
                     exp_t.kind, got.kind, exp_t.has_char, got.has_char, exp_t.char_value,
                     got.char_value, exp_t.starts, got.starts, exp_t.ends, got.ends,
                     exp_t.last, got.last);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while ((pending_bytes.size() != 0 || in_tvalid || expected_tokens.size() != 0)
           && n_cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("xml_token_lexer_tb: done, errors");
      $finish;
    end else begin
      repeat (100) @(posedge clk);
      if (n_errors == 0 && expected_tokens.size() == 0) $display("xml_token_lexer_tb: done, clean");
      else $display("xml_token_lexer_tb: done, errors");
      $finish;
    end
  end

endmodule

[xml_token_lexer.f]
rtl/xtl_pkg.sv
rtl/xtl_datapath.sv
rtl/xtl_ctrl.sv
rtl/xml_token_lexer.sv
rtl/xtl_checker.sv
dv/xml_token_lexer_tb.sv
